FILE: rtl/core/bcts_pkg.sv
// Shared types and constants of the block cache tag store.
// Depends on nothing; every other file of the block imports it.
package bcts_pkg;

	// Tag store geometry
	localparam int unsigned ENTRIES    = 64;
	localparam int unsigned SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned KEY_W      = 64;
	localparam int unsigned SLOT_OUT_W = 6;

	typedef logic [SLOT_W-1:0] slot_t;

	localparam slot_t SLOT_LAST = slot_t'(ENTRIES - 1);

	// Request operations
	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Two-entry queues on both sides of the lookup engine
	typedef logic [1:0] qcnt_t;
	localparam qcnt_t QUEUE_DEPTH = 2'd2;

	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot_index;
	} rsp_t;

	// Head of the request queue as seen by the lookup engine
	typedef struct packed {
		logic avail;
		req_t req;
	} req_head_t;

endpackage

FILE: rtl/core/bcts_front.sv
// Request front end of the block cache tag store: accepts and queues requests.
// Depends on bcts_pkg.
module bcts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bcts_pkg::req_t    req,
	output bcts_pkg::req_head_t head,
	input  logic              head_pop
);
	import bcts_pkg::*;

	req_t  mem_q [QUEUE_DEPTH];
	logic  wr_ptr_q;
	logic  rd_ptr_q;
	qcnt_t cnt_q;
	logic  push_ok;
	logic  pop_ok;
	req_t  req_clean;

	assign full    = (cnt_q == QUEUE_DEPTH);
	assign push_ok = push && !full;
	assign pop_ok  = head_pop && (cnt_q != '0);

	// Classify: only the low operation bit selects probe or fetch
	always_comb begin
		req_clean           = req;
		req_clean.operation = (req.operation == OP_FETCH) ? OP_FETCH : OP_PROBE;
	end

	// Store incoming request
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= req_clean;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + qcnt_t'(push_ok) - qcnt_t'(pop_ok);
		end
	end

	assign head.avail = (cnt_q != '0);
	assign head.req   = mem_q[rd_ptr_q];

endmodule

FILE: rtl/core/bcts_back.sv
// Lookup engine of the block cache tag store: associative match, round-robin
// fill and result queue. Depends on bcts_pkg.
module bcts_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bcts_pkg::req_head_t head,
	output logic                head_pop,
	output logic                empty,
	input  logic                pop,
	output bcts_pkg::rsp_t      rsp
);
	import bcts_pkg::*;

	localparam logic S_IDLE    = 1'b0;
	localparam logic S_RESOLVE = 1'b1;

	logic             state_q;
	logic [KEY_W-1:0] slot_tags_q [ENTRIES];
	logic [ENTRIES-1:0] slot_valid_q;
	slot_t            victim_q;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] match_s1;
	logic               op_s1;
	logic [KEY_W-1:0]   key_s1;

	logic  start;
	logic  hit;
	slot_t enc;
	logic  alloc;
	rsp_t  res;

	rsp_t  out_mem_q [QUEUE_DEPTH];
	logic  out_wr_q;
	logic  out_rd_q;
	qcnt_t out_cnt_q;
	logic  out_push;
	logic  out_pop;

	// Take a request only when a result entry is free
	assign start    = (state_q == S_IDLE) && head.avail && (out_cnt_q != QUEUE_DEPTH);
	assign head_pop = start;

	// Compare the key against every valid slot
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = slot_valid_q[i] && (slot_tags_q[i] == head.req.key);
		end
	end

	// Register match vector and request
	always_ff @(posedge clk) begin
		if (start) begin
			match_s1 <= match;
			op_s1    <= head.req.operation;
			key_s1   <= head.req.key;
		end
	end

	// Encode the match; at most one slot can hold a given key
	always_comb begin
		enc = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			enc = enc | (match_s1[i] ? slot_t'(i) : slot_t'(0));
		end
	end

	assign hit      = |match_s1;
	assign out_push = (state_q == S_RESOLVE);
	assign alloc    = out_push && !hit && (op_s1 == OP_FETCH);

	always_comb begin
		res.hit = hit;
		if (hit) begin
			res.slot_index = SLOT_OUT_W'(enc);
		end else if (op_s1 == OP_FETCH) begin
			res.slot_index = SLOT_OUT_W'(victim_q);
		end else begin
			res.slot_index = '0;
		end
	end

	// Sequence one request at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:    if (start) state_q <= S_RESOLVE;
				S_RESOLVE: state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// Write the key into the victim slot on a fetch miss
	always_ff @(posedge clk) begin
		if (alloc) begin
			slot_tags_q[victim_q] <= key_s1;
		end
	end

	// Mark the slot valid and advance the victim pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			victim_q     <= '0;
		end else if (alloc) begin
			slot_valid_q[victim_q] <= 1'b1;
			victim_q <= (victim_q == SLOT_LAST) ? slot_t'(0) : victim_q + slot_t'(1);
		end
	end

	// Result queue
	assign out_pop = pop && (out_cnt_q != '0);

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			if (out_push) begin
				out_wr_q <= ~out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= ~out_rd_q;
			end
			out_cnt_q <= out_cnt_q + qcnt_t'(out_push) - qcnt_t'(out_pop);
		end
	end

	assign empty = (out_cnt_q == '0);
	assign rsp   = out_mem_q[out_rd_q];

	// A resolve cycle is always followed by an idle cycle
	a_resolve_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESOLVE) |=> (state_q == S_IDLE))
		else $error("lookup engine stayed in resolve");

	// Result queue never overflows
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q == QUEUE_DEPTH) |-> !out_push)
		else $error("result queue overflow");

	// A key is never held in two slots
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESOLVE) |-> $onehot0(match_s1))
		else $error("several slots hold the same key");

	// A fetch miss leaves its slot valid
	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> slot_valid_q[$past(victim_q)])
		else $error("filled slot not valid");

	// Victim pointer stays within the slots
	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		victim_q <= SLOT_LAST)
		else $error("victim pointer out of range");

endmodule

FILE: rtl/core/block_cache_tag_store_core.sv
// Block cache tag store: fully associative tag lookup with first-in
// first-out replacement over ENTRIES slots.
// Channels: requests enter through push/full with payload req (operation,
// key); results leave through empty/pop with payload rsp (hit, slot_index).
// A request transfers on a clock edge with push high and full low; a result
// transfers on a clock edge with pop high and empty low.
// A probe reports hit and slot, or a miss with slot 0. A fetch that misses
// writes its key into the slot under the victim pointer and returns that
// slot with hit low; the pointer then advances round robin.
// A result passes the request queue, the registered match stage and the result
// queue before it is visible. The lookup engine handles one request at a time:
// it compares and registers the match, then resolves and fills, then takes another.
// Two-entry queues sit on both sides, so requests keep transferring while a
// result waits; when the receiver stalls, the result queue fills, the engine
// holds, and full rises once the request queue is full.
// Reset clears all slot valid bits, the victim pointer and both queues at
// once; no clearing pass is needed. Depends on bcts_pkg, bcts_front, bcts_back.
module block_cache_tag_store_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  bcts_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output bcts_pkg::rsp_t rsp
);
	import bcts_pkg::*;

	req_head_t head;
	logic      head_pop;

	// Accept and queue requests
	bcts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.head     (head),
		.head_pop (head_pop)
	);

	// Look up, fill and queue results
	bcts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_pop (head_pop),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule
